// ===== sv/window_stack_focus_manager_macros.svh =====
// Assertion helpers for the window stack block.
// Each helper names the clock, the active-low reset, a condition and what must follow it.
`ifndef WINDOW_STACK_FOCUS_MANAGER_MACROS_SVH
`define WINDOW_STACK_FOCUS_MANAGER_MACROS_SVH
`ifndef SYNTHESIS
`define WSFM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("window stack check failed in the same cycle");
`define WSFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("window stack check failed in the next cycle");
`else
`define WSFM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define WSFM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/wsfm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wsfm_pkg;

    typedef enum logic [2:0] {
        CMD_OPEN     = 3'd0,
        CMD_CLOSE    = 3'd1,
        CMD_RAISE    = 3'd2,
        CMD_MINIMIZE = 3'd3,
        CMD_TOGGLE   = 3'd4,
        CMD_CLEAR    = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_OPEN_OK      = 2'd0,
        KIND_OPEN_FAIL    = 2'd1,
        KIND_FOCUS_LOST   = 2'd2,
        KIND_FOCUS_GAINED = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] slot;
        logic       last;
    } t_evt;

    // Operation broadcast to every cell of the stack row.
    typedef struct packed {
        logic push;
        logic unstack;
        logic raise;
        logic set_min;
        logic set_valid;
        logic clr_valid;
    } t_cell_op;

    localparam int MAX_RES   = 3;
    localparam int PUSH_W    = $clog2(MAX_RES + 1);
    localparam int EVQ_DEPTH = 4;

endpackage

`default_nettype wire

// ===== sv/wsfm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface wsfm_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [3:0] window_slot;

    modport source (output valid, output command, output window_slot, input ready);
    modport sink   (input valid, input command, input window_slot, output ready);
endinterface

interface wsfm_evt_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [3:0] slot;
    logic       last;

    modport source (output valid, output kind, output slot, output last, input ready);
    modport sink   (input valid, input kind, input slot, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/window_stack_focus_manager.sv =====
// Window stack and focus manager. Each command transaction (open, close, raise, minimize,
// taskbar toggle, clear focus) updates a bottom-to-top stacking order of window slots held in
// a row of SLOTS cells, plus per-slot valid and minimized flags, and produces up to three
// event transactions: open ok or fail, focus lost, focus gained, with last set on the final
// one. Close, raise, minimize and toggle on an invalid slot, and unknown codes, produce nothing.
// Timing: raise, clear, a close of an unfocused slot and every ignored command pass through
// the look and execute states and return to idle. Open and every command that has to find the
// topmost visible window (minimize, toggle-to-minimize, close of the focused slot) also wait
// until the two search chains in the cell row have settled after the last change of stack or
// flags. The search crosses one cell per cycle, so the row length sets how long that wait lasts.
// Events queue in a 4-deep buffer; a command is accepted only while the buffer has room for
// three more events.
`timescale 1ns / 1ps
`default_nettype none
`include "window_stack_focus_manager_macros.svh"

module window_stack_focus_manager #(
    parameter int SLOTS = 16
) (
    input wire          i_clk,
    input wire          i_rst_n,
    wsfm_cmd_if.sink    i_cmd,
    wsfm_evt_if.source  o_evt
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int IW = ((SW > 4) ? SW : 4) + 1;
    localparam int NP = 2 ** SW;
    localparam logic [CW-1:0] SETTLE_DONE = CW'(SLOTS);

    typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_EXEC, ST_SEARCH} t_state;

    t_state               r_state, n_state;
    wsfm_pkg::t_cmd       r_cmd;
    logic [SW-1:0]        r_key;
    logic                 r_in_range;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_fp, n_fp;
    logic [SW-1:0]        r_focus, n_focus;
    logic [CW-1:0]        r_settle;

    wsfm_pkg::t_cell_op   w_op;
    logic [SW-1:0]        w_key_bus;
    logic                 w_change;
    logic [wsfm_pkg::PUSH_W-1:0] w_push_n;
    wsfm_pkg::t_evt       w_items [wsfm_pkg::MAX_RES];
    logic [1:0]           w_notes;

    // cell row links
    logic [SW-1:0] w_entry    [SLOTS];
    logic          w_min      [SLOTS];
    logic [SW-1:0] w_up_entry [SLOTS];
    logic          w_up_min   [SLOTS];
    logic          w_shift    [SLOTS+1];
    logic          w_best_found [SLOTS+1];
    logic [SW-1:0] w_best_slot  [SLOTS+1];
    logic          w_free_found [SLOTS+1];
    logic [SW-1:0] w_free_slot  [SLOTS+1];
    logic [SLOTS-1:0] w_valid_vec;
    logic [SLOTS-1:0] w_hitmin_vec;
    logic [NP-1:0]    w_valid_pad;

    logic w_accept, w_room, w_settled, w_ok, w_focused_here, w_sel_min;
    logic w_do_raise, w_do_min;
    logic [IW-1:0] w_slot_ext;
    wsfm_pkg::t_evt w_head;

    // {lost, gained} notices for a focus move, lost only to a slot that is still valid
    function automatic logic [1:0] f_focus_notes(logic had, logic [SW-1:0] old, logic old_ok,
                                                 logic has_new, logic [SW-1:0] s);
        logic same;
        same = (had == has_new) && (!had || old == s);
        return {!same && had && old_ok, !same && has_new};
    endfunction

    assign w_shift[0]          = 1'b0;
    assign w_best_found[SLOTS] = 1'b0;
    assign w_best_slot[SLOTS]  = '0;
    assign w_free_found[0]     = 1'b0;
    assign w_free_slot[0]      = '0;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        if (i == SLOTS - 1) begin : g_top
            assign w_up_entry[i] = '0;
            assign w_up_min[i]   = 1'b0;
        end else begin : g_mid
            assign w_up_entry[i] = w_entry[i+1];
            assign w_up_min[i]   = w_min[i+1];
        end

        wsfm_cell #(
            .SW  (SW),
            .CW  (CW),
            .POS (i)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (w_op),
            .i_key        (w_key_bus),
            .i_count      (r_count),
            .i_up_entry   (w_up_entry[i]),
            .i_up_min     (w_up_min[i]),
            .o_entry      (w_entry[i]),
            .o_min        (w_min[i]),
            .i_shift      (w_shift[i]),
            .o_shift      (w_shift[i+1]),
            .i_best_found (w_best_found[i+1]),
            .i_best_slot  (w_best_slot[i+1]),
            .o_best_found (w_best_found[i]),
            .o_best_slot  (w_best_slot[i]),
            .i_free_found (w_free_found[i]),
            .i_free_slot  (w_free_slot[i]),
            .o_free_found (w_free_found[i+1]),
            .o_free_slot  (w_free_slot[i+1]),
            .o_valid      (w_valid_vec[i]),
            .o_hit_min    (w_hitmin_vec[i])
        );
    end

    assign w_valid_pad = NP'(w_valid_vec);

    wsfm_evq u_evq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_items  (w_items),
        .o_room   (w_room),
        .o_valid  (o_evt.valid),
        .o_item   (w_head),
        .i_ready  (o_evt.ready)
    );

    assign o_evt.kind = w_head.kind;
    assign o_evt.slot = w_head.slot;
    assign o_evt.last = w_head.last;

    // Take a command only when idle and the event buffer can hold a full burst.
    assign i_cmd.ready = (r_state == ST_IDLE) && w_room;
    assign w_accept    = i_cmd.valid && (r_state == ST_IDLE) && w_room;
    assign w_slot_ext  = IW'(i_cmd.window_slot);

    assign w_settled      = r_settle == SETTLE_DONE;
    assign w_ok           = r_in_range && w_valid_pad[r_key];
    assign w_focused_here = r_fp && (r_focus == r_key);
    assign w_sel_min      = |w_hitmin_vec;

    // Toggle acts as minimize on the focused, visible slot and as raise on any other.
    assign w_do_min   = (r_state == ST_EXEC) && w_ok &&
                        ((r_cmd == wsfm_pkg::CMD_MINIMIZE) ||
                         ((r_cmd == wsfm_pkg::CMD_TOGGLE) && w_focused_here && !w_sel_min));
    assign w_do_raise = (r_state == ST_EXEC) && w_ok &&
                        ((r_cmd == wsfm_pkg::CMD_RAISE) ||
                         ((r_cmd == wsfm_pkg::CMD_TOGGLE) && !(w_focused_here && !w_sel_min)));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_fp      = r_fp;
        n_focus   = r_focus;
        w_op      = '0;
        w_change  = 1'b0;
        w_push_n  = '0;
        w_items   = '{default: '0};
        w_notes   = '0;
        // open writes the free slot into the row, everything else works on the command slot
        w_key_bus = (r_cmd == wsfm_pkg::CMD_OPEN) ? w_free_slot[SLOTS] : r_key;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                // let every cell compare its entry with the command slot
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                case (r_cmd)
                    wsfm_pkg::CMD_OPEN: begin
                        if (w_settled) begin
                            n_state = ST_IDLE;
                            if (!w_free_found[SLOTS]) begin
                                w_items[w_push_n] = '{kind: wsfm_pkg::KIND_OPEN_FAIL,
                                                      slot: 4'd0, last: 1'b0};
                                w_push_n = w_push_n + 1'b1;
                            end else begin
                                w_op.push      = 1'b1;
                                w_op.set_valid = 1'b1;
                                w_change       = 1'b1;
                                n_count        = r_count + CW'(1);
                                w_items[w_push_n] = '{kind: wsfm_pkg::KIND_OPEN_OK,
                                                      slot: 4'(w_free_slot[SLOTS]),
                                                      last: 1'b0};
                                w_push_n = w_push_n + 1'b1;
                                w_notes = f_focus_notes(r_fp, r_focus, w_valid_pad[r_focus],
                                                        1'b1, w_free_slot[SLOTS]);
                                if (w_notes[1]) begin
                                    w_items[w_push_n] = '{kind: wsfm_pkg::KIND_FOCUS_LOST,
                                                          slot: 4'(r_focus), last: 1'b0};
                                    w_push_n = w_push_n + 1'b1;
                                end
                                if (w_notes[0]) begin
                                    w_items[w_push_n] = '{kind: wsfm_pkg::KIND_FOCUS_GAINED,
                                                          slot: 4'(w_free_slot[SLOTS]),
                                                          last: 1'b0};
                                    w_push_n = w_push_n + 1'b1;
                                end
                                n_fp    = 1'b1;
                                n_focus = w_free_slot[SLOTS];
                            end
                        end
                    end
                    wsfm_pkg::CMD_CLOSE: begin
                        n_state = ST_IDLE;
                        if (w_ok) begin
                            w_op.clr_valid = 1'b1;
                            w_op.unstack   = 1'b1;
                            w_change       = 1'b1;
                            n_count        = r_count - CW'(1);
                            if (w_focused_here) begin
                                n_state = ST_SEARCH;
                            end
                        end
                    end
                    wsfm_pkg::CMD_RAISE, wsfm_pkg::CMD_MINIMIZE, wsfm_pkg::CMD_TOGGLE: begin
                        n_state = ST_IDLE;
                        if (w_do_raise) begin
                            w_op.raise = 1'b1;
                            w_change   = 1'b1;
                            w_notes = f_focus_notes(r_fp, r_focus, w_valid_pad[r_focus],
                                                    1'b1, r_key);
                            if (w_notes[1]) begin
                                w_items[w_push_n] = '{kind: wsfm_pkg::KIND_FOCUS_LOST,
                                                      slot: 4'(r_focus), last: 1'b0};
                                w_push_n = w_push_n + 1'b1;
                            end
                            if (w_notes[0]) begin
                                w_items[w_push_n] = '{kind: wsfm_pkg::KIND_FOCUS_GAINED,
                                                      slot: 4'(r_key), last: 1'b0};
                                w_push_n = w_push_n + 1'b1;
                            end
                            n_fp    = 1'b1;
                            n_focus = r_key;
                        end else if (w_do_min) begin
                            w_op.set_min = 1'b1;
                            w_change     = 1'b1;
                            n_state      = ST_SEARCH;
                        end
                    end
                    wsfm_pkg::CMD_CLEAR: begin
                        n_state = ST_IDLE;
                        w_notes = f_focus_notes(r_fp, r_focus, w_valid_pad[r_focus],
                                                1'b0, '0);
                        if (w_notes[1]) begin
                            w_items[w_push_n] = '{kind: wsfm_pkg::KIND_FOCUS_LOST,
                                                  slot: 4'(r_focus), last: 1'b0};
                            w_push_n = w_push_n + 1'b1;
                        end
                        n_fp    = 1'b0;
                        n_focus = '0;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_SEARCH: begin
                // wait for the top-down chain to reach cell 0, then refocus
                if (w_settled) begin
                    n_state = ST_IDLE;
                    w_notes = f_focus_notes(r_fp, r_focus, w_valid_pad[r_focus],
                                            w_best_found[0], w_best_slot[0]);
                    if (w_notes[1]) begin
                        w_items[w_push_n] = '{kind: wsfm_pkg::KIND_FOCUS_LOST,
                                              slot: 4'(r_focus), last: 1'b0};
                        w_push_n = w_push_n + 1'b1;
                    end
                    if (w_notes[0]) begin
                        w_items[w_push_n] = '{kind: wsfm_pkg::KIND_FOCUS_GAINED,
                                              slot: 4'(w_best_slot[0]), last: 1'b0};
                        w_push_n = w_push_n + 1'b1;
                    end
                    n_fp    = w_best_found[0];
                    n_focus = w_best_found[0] ? w_best_slot[0] : '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // mark the final event of the burst
        if (w_push_n != '0) begin
            w_items[w_push_n - 1'b1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_fp     <= 1'b0;
            r_focus  <= '0;
            r_settle <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_fp    <= n_fp;
            r_focus <= n_focus;
            // restart the settle count on any change of the row, saturate once settled
            if (w_change) begin
                r_settle <= '0;
            end else if (!w_settled) begin
                r_settle <= r_settle + CW'(1);
            end
        end
    end

    // Latch the command transaction.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= wsfm_pkg::t_cmd'(i_cmd.command);
            r_key      <= w_slot_ext[SW-1:0];
            r_in_range <= w_slot_ext < IW'(SLOTS);
        end
    end

    `WSFM_ASSERT_NOW(a_focus_valid, i_clk, i_rst_n, (r_state == ST_IDLE) && r_fp, w_valid_pad[r_focus])
    `WSFM_ASSERT_NOW(a_count_matches, i_clk, i_rst_n, r_state == ST_IDLE, 32'(r_count) == $countones(w_valid_vec))
    `WSFM_ASSERT_NOW(a_free_settled, i_clk, i_rst_n, w_settled, w_free_found[SLOTS] == !(&w_valid_vec))

endmodule

`default_nettype wire

// ===== sv/wsfm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wsfm_cell #(
    parameter int SW  = 4,
    parameter int CW  = 5,
    parameter int POS = 0
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire wsfm_pkg::t_cell_op i_op,
    input  wire  [SW-1:0]        i_key,
    input  wire  [CW-1:0]        i_count,
    input  wire  [SW-1:0]        i_up_entry,
    input  wire                  i_up_min,
    output logic [SW-1:0]        o_entry,
    output logic                 o_min,
    input  wire                  i_shift,
    output logic                 o_shift,
    input  wire                  i_best_found,
    input  wire  [SW-1:0]        i_best_slot,
    output logic                 o_best_found,
    output logic [SW-1:0]        o_best_slot,
    input  wire                  i_free_found,
    input  wire  [SW-1:0]        i_free_slot,
    output logic                 o_free_found,
    output logic [SW-1:0]        o_free_slot,
    output logic                 o_valid,
    output logic                 o_hit_min
);

    localparam logic [CW-1:0] POS_C = CW'(POS);
    localparam logic [SW-1:0] SID   = SW'(POS);

    logic [SW-1:0] r_entry, n_entry;
    logic          r_min, n_min;
    logic          r_hit;
    logic          r_valid;
    logic          r_best_found;
    logic [SW-1:0] r_best_slot;
    logic          r_free_found;
    logic [SW-1:0] r_free_slot;

    logic w_occ, w_shift_me, w_is_top, w_vis;

    assign w_occ      = POS_C < i_count;
    assign w_shift_me = i_shift | r_hit;
    assign w_is_top   = POS_C == (i_count - CW'(1));
    assign w_vis      = w_occ & ~r_min;

    always_comb begin
        n_entry = r_entry;
        n_min   = r_min;
        if (i_op.push && POS_C == i_count) begin
            n_entry = i_key;
            n_min   = 1'b0;
        end else if ((i_op.unstack || i_op.raise) && w_shift_me) begin
            // the raised slot lands on top, everything above the hit moves down
            if (i_op.raise && w_is_top) begin
                n_entry = i_key;
                n_min   = 1'b0;
            end else begin
                n_entry = i_up_entry;
                n_min   = i_up_min;
            end
        end
        if (i_op.set_min && r_hit) begin
            n_min = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry      <= n_entry;
        r_min        <= n_min;
        r_hit        <= w_occ && (r_entry == i_key);
        // top-down chain: topmost visible entry at or above this cell
        r_best_found <= i_best_found | w_vis;
        r_best_slot  <= i_best_found ? i_best_slot : r_entry;
        // bottom-up chain: lowest free slot at or below this cell
        r_free_found <= i_free_found | ~r_valid;
        r_free_slot  <= i_free_found ? i_free_slot : SID;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_op.set_valid && i_key == SID) begin
            r_valid <= 1'b1;
        end else if (i_op.clr_valid && i_key == SID) begin
            r_valid <= 1'b0;
        end
    end

    assign o_entry      = r_entry;
    assign o_min        = r_min;
    assign o_shift      = w_shift_me;
    assign o_best_found = r_best_found;
    assign o_best_slot  = r_best_slot;
    assign o_free_found = r_free_found;
    assign o_free_slot  = r_free_slot;
    assign o_valid      = r_valid;
    assign o_hit_min    = r_hit & r_min;

endmodule

`default_nettype wire

// ===== sv/wsfm_evq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wsfm_evq (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire  [wsfm_pkg::PUSH_W-1:0]   i_push_n,
    input  wire wsfm_pkg::t_evt           i_items [wsfm_pkg::MAX_RES],
    output logic                          o_room,
    output logic                          o_valid,
    output wsfm_pkg::t_evt                o_item,
    input  wire                           i_ready
);

    localparam int D   = wsfm_pkg::EVQ_DEPTH;
    localparam int QCW = $clog2(D + 1);

    wsfm_pkg::t_evt r_q [D];
    wsfm_pkg::t_evt n_q [D];
    logic [QCW-1:0] r_cnt;
    logic [QCW-1:0] w_base;
    logic           w_pop;

    assign w_pop  = (r_cnt != '0) && i_ready;
    assign w_base = r_cnt - QCW'(w_pop);

    for (genvar j = 0; j < D; j++) begin : g_ent
        logic [QCW-1:0] w_off;
        assign w_off = QCW'(j) - w_base;
        always_comb begin
            n_q[j] = r_q[j];
            if (QCW'(j) < w_base) begin
                // hold, or advance toward the head on a pop
                if (w_pop) begin
                    n_q[j] = (j < D - 1) ? r_q[(j < D - 1) ? j + 1 : j] : r_q[j];
                end
            end else if (w_off < QCW'(i_push_n)) begin
                n_q[j] = i_items[w_off[wsfm_pkg::PUSH_W-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= w_base + QCW'(i_push_n);
        end
    end

    assign o_room  = r_cnt <= QCW'(D - wsfm_pkg::MAX_RES);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_q[0];

endmodule

`default_nettype wire
